// ===== rtl/scma_pkg.sv =====
// shared types, codes and the saturating add of the sparse column matrix assembler
// no dependencies; used by the top level, the checker and the testbench

`default_nettype none

package scma_pkg;

	typedef enum logic [1:0] {
		OP_RESERVE = 2'd0,
		OP_ADD     = 2'd1,
		OP_SHIFT   = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_LOWER       = 3'd1,
		ST_WRONG_PHASE = 3'd2,
		ST_ROW_RANGE   = 3'd3,
		ST_COL_RANGE   = 3'd4,
		ST_COL_FULL    = 3'd5,
		ST_OVERFLOW    = 3'd6,
		ST_BAD_SLOT    = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_DEC,
		S_COL_RD,
		S_DISP,
		S_SRCH,
		S_ISSUE,
		S_APPLY,
		S_SH_COL,
		S_SH_SLOT,
		S_SH_WR,
		S_FIN
	} state_t;

	localparam int VAL_W = 40;

	typedef struct packed {
		logic [7:0]              row;
		logic signed [VAL_W-1:0] value;
	} slot_ent_t;

	// q24.16 accumulate of a q16.16 amount, clamped to the 40-bit range
	function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] v,
			input logic signed [31:0] a);
		logic signed [VAL_W:0] s;
		s = (VAL_W+1)'(v) + (VAL_W+1)'(a);
		if (s[VAL_W] != s[VAL_W-1]) begin
			return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return s[VAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/scma_if.sv =====
// valid/ready channels of the sparse column matrix assembler: item, result, config
// no dependencies

`default_nettype none

interface scma_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [7:0]         row;
	logic [7:0]         column;
	logic signed [31:0] amount;
	logic               definitely_new;
	logic [12:0]        capacity;
	logic [11:0]        slot;
	modport source (output valid, operation, row, column, amount, definitely_new, capacity,
		slot, input ready);
	modport sink (input valid, operation, row, column, amount, definitely_new, capacity,
		slot, output ready);
endinterface

interface scma_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [7:0]         row_index;
	logic signed [39:0] entry_value;
	logic [12:0]        entries_used;
	modport source (output valid, status, row_index, entry_value, entries_used, input ready);
	modport sink (input valid, status, row_index, entry_value, entries_used, output ready);
endinterface

interface scma_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] matrix_size;
	modport source (output valid, matrix_size, input ready);
	modport sink (input valid, matrix_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/sparse_column_matrix_assembler.sv =====
// upper-triangular sparse matrix assembler in column-compressed storage
// depends on scma_pkg and the channel interfaces in scma_if

`default_nettype none

// Builds an upper-triangular sparse matrix with reserved slots per column. Reserve items
// hand out column capacities in order (slot 0 of a column is its diagonal); once
// matrix_size columns exist, add, shift and read items work on the store. State sits in two
// synchronous memories, a column table {start, limit, used} and a slot store {row, value},
// each with a registered read. After reset a clearing pass zeroes the slot store, during
// which no item is taken (config writes still are). Reserve and any item refused at decode
// go straight to the result; a read of a bad slot and an add to a full column skip the slot
// update. A searched add scans the used slots of the column (one slot per cycle through the
// slot store port) and stops when the row turns up; a shift adds the amount to the diagonal
// slot of each column, column by column. One item is worked at a time; a finished result
// sits in an output register so the next item can be taken before it is collected.
// matrix_size is only written before the first reserve.
module sparse_column_matrix_assembler #(
	parameter int MAX_DIM   = 256,
	parameter int MAX_SLOTS = 4096
) (
	input  wire            clk,
	input  wire            arst_n,
	scma_item_if.sink      item,
	scma_result_if.source  result,
	scma_cfg_if.sink       cfg
);
	import scma_pkg::*;

	localparam int CAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNW = CAW + 1;                 // column counts up to MAX_DIM
	localparam int SAW = $clog2(MAX_SLOTS);
	localparam int SCW = SAW + 1;                 // slot counts up to MAX_SLOTS

	typedef struct packed {
		logic [SCW-1:0] start;
		logic [SCW-1:0] limit;
		logic [SCW-1:0] used;
	} col_ent_t;

	// memories
	col_ent_t  col_mem [MAX_DIM];
	slot_ent_t slot_mem [MAX_SLOTS];
	col_ent_t  col_rd;
	slot_ent_t slot_rd;

	// memory port controls
	logic           col_we;
	logic [CAW-1:0] col_waddr, col_raddr;
	col_ent_t       col_wdata;
	logic           slot_we;
	logic [SAW-1:0] slot_waddr, slot_raddr;
	slot_ent_t      slot_wdata;

	// control state
	state_t         state_q, state_d;
	logic [SAW-1:0] clr_q;
	logic           phase_q;
	logic [CNW-1:0] next_col_q;
	logic [SCW-1:0] alloc_q;
	logic [CNW-1:0] size_q;
	logic           out_valid_q;

	// latched item
	op_t                op_q;
	logic [7:0]         row_q, col_q;
	logic signed [31:0] amount_q;
	logic               new_q;
	logic [12:0]        cap_q;
	logic [11:0]        slot_q;

	// working registers
	logic [SCW-1:0] start_q, limit_q, used_q;
	logic [SCW-1:0] srch_q;
	logic           pend_q;
	logic [SAW-1:0] pend_addr_q;
	logic [SAW-1:0] upd_addr_q;
	logic           inc_q;
	logic [CNW-1:0] sh_c_q;

	// result staging and output register
	status_t            res_status_q;
	logic [7:0]         res_row_q;
	logic signed [39:0] res_val_q;
	logic [12:0]        res_used_q;
	status_t            out_status_q;
	logic [7:0]         out_row_q;
	logic signed [39:0] out_val_q;
	logic [12:0]        out_used_q;

	// checks on the latched item
	logic           out_free;
	logic           row_ge, col_ge, lower, diag;
	logic           add_err, read_err, rsv_err, rsv_ovf;
	logic [12:0]    cap_eff;
	logic [SCW-1:0] app_start, app_used, app_limit, app_loc;
	logic           app_full, srch_more, match, read_bad, sh_last;
	logic signed [39:0] sum;
	logic [8:0]     cfg_v;

	assign out_free  = !out_valid_q || result.ready;
	assign row_ge    = 32'(row_q) >= 32'(size_q);
	assign col_ge    = 32'(col_q) >= 32'(size_q);
	assign lower     = col_q < row_q;
	assign diag      = row_q == col_q;
	assign add_err   = lower || !phase_q || row_ge || col_ge;
	assign read_err  = !phase_q || col_ge;
	assign rsv_err   = phase_q || (next_col_q >= size_q);
	assign cap_eff   = (cap_q == 13'd0) ? 13'd1 : cap_q;
	assign rsv_ovf   = (32'(alloc_q) + 32'(cap_eff)) > MAX_SLOTS;

	// append target: the column table data right after its read, else the held copy
	assign app_start = (state_q == S_DISP) ? col_rd.start : start_q;
	assign app_used  = (state_q == S_DISP) ? col_rd.used  : used_q;
	assign app_limit = (state_q == S_DISP) ? col_rd.limit : limit_q;
	assign app_loc   = app_start + app_used;
	assign app_full  = app_loc >= app_limit;

	assign srch_more = srch_q < (start_q + used_q);
	assign match     = pend_q && (slot_rd.row == row_q);
	assign read_bad  = (32'(slot_q) >= 32'(col_rd.used))
		|| ((32'(col_rd.start) + 32'(slot_q)) >= MAX_SLOTS);
	assign sh_last   = (32'(sh_c_q) + 32'd1) >= 32'(size_q);
	assign sum       = sat_add(slot_rd.value, amount_q);

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign cfg_v      = (cfg.matrix_size == 9'd0) ? 9'd1 : cfg.matrix_size;

	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.row_index    = out_row_q;
	assign result.entry_value  = out_val_q;
	assign result.entries_used = out_used_q;

	// memories: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_waddr] <= col_wdata;
		end
		col_rd <= col_mem[col_raddr];
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd <= slot_mem[slot_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (clr_q == SAW'(MAX_SLOTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (item.valid) state_d = S_DEC;
			end
			S_DEC: begin
				unique case (op_q)
					OP_RESERVE: state_d = S_FIN;
					OP_ADD:     state_d = add_err ? S_FIN : S_COL_RD;
					OP_SHIFT:   state_d = phase_q ? S_SH_COL : S_FIN;
					OP_READ:    state_d = read_err ? S_FIN : S_COL_RD;
					default:    state_d = S_FIN;
				endcase
			end
			S_COL_RD: state_d = S_DISP;
			S_DISP: begin
				if (op_q == OP_READ) begin
					state_d = read_bad ? S_FIN : S_ISSUE;
				end else if (diag) begin
					state_d = S_ISSUE;
				end else if (new_q) begin
					state_d = app_full ? S_FIN : S_ISSUE;
				end else begin
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (match) begin
					state_d = S_ISSUE;
				end else if (!srch_more) begin
					state_d = app_full ? S_FIN : S_ISSUE;
				end
			end
			S_ISSUE:   state_d = S_APPLY;
			S_APPLY:   state_d = S_FIN;
			S_SH_COL:  state_d = S_SH_SLOT;
			S_SH_SLOT: state_d = S_SH_WR;
			S_SH_WR:   state_d = sh_last ? S_FIN : S_SH_COL;
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		col_we     = 1'b0;
		col_waddr  = CAW'(col_q);
		col_wdata  = '{start: start_q, limit: limit_q, used: used_q + SCW'(1)};
		col_raddr  = (state_q == S_SH_COL) ? CAW'(sh_c_q) : CAW'(col_q);
		slot_we    = 1'b0;
		slot_waddr = upd_addr_q;
		slot_wdata = '{row: row_q, value: sum};
		slot_raddr = upd_addr_q;
		unique case (state_q)
			S_CLR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '0;
			end
			S_DEC: begin
				if (op_q == OP_RESERVE && !rsv_err && !rsv_ovf) begin
					col_we     = 1'b1;
					col_waddr  = CAW'(next_col_q);
					col_wdata  = '{start: alloc_q,
						limit: SCW'(32'(alloc_q) + 32'(cap_eff)), used: SCW'(1)};
					slot_we    = 1'b1;
					slot_waddr = SAW'(alloc_q);
					slot_wdata = '{row: 8'(next_col_q), value: '0};
				end
			end
			S_SRCH:    slot_raddr = SAW'(srch_q);
			S_SH_SLOT: slot_raddr = SAW'(col_rd.start);
			S_APPLY: begin
				if (op_q != OP_READ) begin
					slot_we = 1'b1;
					col_we  = inc_q;
				end
			end
			S_SH_WR: begin
				slot_we    = 1'b1;
				slot_waddr = SAW'(start_q);
				slot_wdata = '{row: slot_rd.row, value: sum};
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			phase_q     <= 1'b0;
			next_col_q  <= '0;
			alloc_q     <= '0;
			size_q      <= CNW'(MAX_DIM);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + SAW'(1);
			end
			// size is frozen once the first column is reserved
			if (cfg.valid && cfg.ready && !phase_q && next_col_q == '0) begin
				size_q <= (32'(cfg_v) > MAX_DIM) ? CNW'(MAX_DIM) : CNW'(cfg_v);
			end
			if (state_q == S_DEC && op_q == OP_RESERVE && !rsv_err && !rsv_ovf) begin
				alloc_q    <= SCW'(32'(alloc_q) + 32'(cap_eff));
				next_col_q <= next_col_q + CNW'(1);
				if ((next_col_q + CNW'(1)) >= size_q) phase_q <= 1'b1;
			end
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item, working and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q     <= op_t'(item.operation);
				row_q    <= item.row;
				col_q    <= item.column;
				amount_q <= item.amount;
				new_q    <= item.definitely_new;
				cap_q    <= item.capacity;
				slot_q   <= item.slot;
			end
			S_DEC: begin
				res_row_q  <= '0;
				res_val_q  <= '0;
				res_used_q <= '0;
				res_status_q <= ST_OK;
				unique case (op_q)
					OP_RESERVE: begin
						if (rsv_err) begin
							res_status_q <= ST_WRONG_PHASE;
						end else if (rsv_ovf) begin
							res_status_q <= ST_OVERFLOW;
						end else begin
							// a fresh diagonal slot still holds its cleared zero
							res_row_q  <= 8'(next_col_q);
							res_used_q <= 13'd1;
						end
					end
					OP_ADD: begin
						if (lower) res_status_q <= ST_LOWER;
						else if (!phase_q) res_status_q <= ST_WRONG_PHASE;
						else if (row_ge) res_status_q <= ST_ROW_RANGE;
						else if (col_ge) res_status_q <= ST_COL_RANGE;
					end
					OP_SHIFT: begin
						if (!phase_q) res_status_q <= ST_WRONG_PHASE;
						sh_c_q <= '0;
					end
					OP_READ: begin
						if (!phase_q) res_status_q <= ST_WRONG_PHASE;
						else if (col_ge) res_status_q <= ST_COL_RANGE;
					end
					default: ;
				endcase
			end
			S_DISP: begin
				start_q <= col_rd.start;
				limit_q <= col_rd.limit;
				used_q  <= col_rd.used;
				inc_q   <= 1'b0;
				pend_q  <= 1'b0;
				srch_q  <= col_rd.start + SCW'(1);
				if (op_q == OP_READ) begin
					if (read_bad) res_status_q <= ST_BAD_SLOT;
					upd_addr_q <= SAW'(32'(col_rd.start) + 32'(slot_q));
				end else if (diag) begin
					upd_addr_q <= SAW'(col_rd.start);
				end else if (new_q) begin
					if (app_full) begin
						res_status_q <= ST_COL_FULL;
						res_used_q   <= 13'(col_rd.used);
					end
					upd_addr_q <= SAW'(app_loc);
					inc_q      <= 1'b1;
				end
			end
			S_SRCH: begin
				// read of one slot in flight while the previous one is compared
				if (match) begin
					upd_addr_q <= pend_addr_q;
				end else if (srch_more) begin
					pend_q      <= 1'b1;
					pend_addr_q <= SAW'(srch_q);
					srch_q      <= srch_q + SCW'(1);
				end else begin
					if (app_full) begin
						res_status_q <= ST_COL_FULL;
						res_used_q   <= 13'(used_q);
					end
					upd_addr_q <= SAW'(app_loc);
					inc_q      <= 1'b1;
				end
			end
			S_APPLY: begin
				res_status_q <= ST_OK;
				if (op_q == OP_READ) begin
					res_row_q  <= slot_rd.row;
					res_val_q  <= slot_rd.value;
					res_used_q <= 13'(used_q);
				end else begin
					res_row_q  <= row_q;
					res_val_q  <= sum;
					res_used_q <= inc_q ? 13'(used_q + SCW'(1)) : 13'(used_q);
				end
			end
			S_SH_SLOT: start_q <= col_rd.start;
			S_SH_WR:   sh_c_q  <= sh_c_q + CNW'(1);
			S_FIN: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_row_q    <= res_row_q;
					out_val_q    <= res_val_q;
					out_used_q   <= res_used_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// once reserved, the phase never returns to reserving
	a_phase_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(phase_q))
		else $error("reserved phase dropped");

	// allocation never runs past the slot store
	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(alloc_q) <= MAX_SLOTS)
		else $error("slot allocation beyond store");

	// the phase turns over exactly when the last column is reserved
	a_phase_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q) |-> next_col_q == size_q)
		else $error("phase entered with columns missing");

	// no item is taken before the clearing pass is done
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |=> $past(!item.ready))
		else $error("item taken during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== verif/scma_checker.sv =====
// checker of the sparse column matrix assembler: watches the item, result and config channels,
// keeps its own copy of the matrix store, predicts each result and compares it
// depends on scma_pkg and the channel interfaces in scma_if

module scma_checker #(
	parameter int MAX_DIM   = 256,
	parameter int MAX_SLOTS = 4096
) (
	input  logic    clk,
	input  logic    arst_n,
	scma_item_if    item,
	scma_result_if  result,
	scma_cfg_if     cfg,
	output int      pending,
	output int      failures
);
	import scma_pkg::*;

	localparam longint VMAX = 64'sd549755813887;
	localparam longint VMIN = -64'sd549755813888;

	typedef struct {
		status_t                st;
		logic [7:0]             row;
		logic signed [39:0]     val;
		logic [12:0]            used;
	} entry_result_t;

	int                 size;
	bit                 built;
	int                 next_col;
	int                 alloc;
	int                 col_start [MAX_DIM+1];
	int                 col_used [MAX_DIM];
	logic [7:0]         row_of [MAX_SLOTS];
	logic signed [39:0] val_of [MAX_SLOTS];
	entry_result_t      expected_q [$];

	initial begin
		size = MAX_DIM;
		built = 0;
		next_col = 0;
		alloc = 0;
		pending = 0;
		failures = 0;
		foreach (val_of[i]) val_of[i] = '0;
		foreach (row_of[i]) row_of[i] = '0;
	end

	function automatic logic signed [39:0] clamp_sum(logic signed [39:0] v,
			logic signed [31:0] a);
		longint s;
		s = longint'(v) + longint'(a);
		if (s > VMAX) s = VMAX;
		if (s < VMIN) s = VMIN;
		return s[39:0];
	endfunction

	function automatic void apply_size(logic [8:0] data);
		int v;
		v = data;
		if (built || next_col != 0) return;
		if (v < 1) v = 1;
		if (v > MAX_DIM) v = MAX_DIM;
		size = v;
	endfunction

	function automatic entry_result_t predict_entry(op_t op, logic [7:0] row, logic [7:0] col,
			logic signed [31:0] amt, logic nw, logic [12:0] cap, logic [11:0] slot);
		entry_result_t r;
		int c, start, used, loc, capn, idx;
		bit hit;
		r.st = ST_OK;
		r.row = '0;
		r.val = '0;
		r.used = '0;
		case (op)
			OP_RESERVE: begin
				if (built || next_col >= size) begin
					r.st = ST_WRONG_PHASE;
					return r;
				end
				capn = (cap == 0) ? 1 : int'(cap);
				if (alloc + capn > MAX_SLOTS) begin
					r.st = ST_OVERFLOW;
					return r;
				end
				c = next_col;
				col_start[c] = alloc;
				col_used[c] = 1;
				row_of[alloc] = c[7:0];
				alloc += capn;
				next_col = c + 1;
				if (next_col >= size) begin
					col_start[next_col] = alloc;
					built = 1;
				end
				r.row = c[7:0];
				r.val = val_of[col_start[c]];
				r.used = 1;
			end
			OP_ADD: begin
				if (col < row) r.st = ST_LOWER;
				else if (!built) r.st = ST_WRONG_PHASE;
				else if (row >= size) r.st = ST_ROW_RANGE;
				else if (col >= size) r.st = ST_COL_RANGE;
				if (r.st != ST_OK) return r;
				start = col_start[col];
				used = col_used[col];
				if (row == col) begin
					val_of[start] = clamp_sum(val_of[start], amt);
					r.row = row;
					r.val = val_of[start];
					r.used = used;
					return r;
				end
				hit = 0;
				loc = 0;
				if (!nw) begin
					for (int i = start + 1; i < start + used && i < MAX_SLOTS; i++) begin
						if (!hit && row_of[i] == row) begin
							loc = i;
							hit = 1;
						end
					end
				end
				if (!hit) begin
					loc = start + used;
					if (loc >= col_start[col+1] || loc >= MAX_SLOTS) begin
						r.st = ST_COL_FULL;
						r.used = used;
						return r;
					end
					row_of[loc] = row;
					col_used[col] = used + 1;
				end
				val_of[loc] = clamp_sum(val_of[loc], amt);
				r.row = row;
				r.val = val_of[loc];
				r.used = col_used[col];
			end
			OP_SHIFT: begin
				if (!built) begin
					r.st = ST_WRONG_PHASE;
					return r;
				end
				for (int k = 0; k < size; k++)
					val_of[col_start[k]] = clamp_sum(val_of[col_start[k]], amt);
			end
			default: begin
				if (!built) r.st = ST_WRONG_PHASE;
				else if (col >= size) r.st = ST_COL_RANGE;
				else if (slot >= col_used[col]) r.st = ST_BAD_SLOT;
				if (r.st != ST_OK) return r;
				idx = col_start[col] + slot;
				if (idx >= MAX_SLOTS) begin
					r.st = ST_BAD_SLOT;
					return r;
				end
				r.row = row_of[idx];
				r.val = val_of[idx];
				r.used = col_used[col];
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		entry_result_t e;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				apply_size(cfg.matrix_size);
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no expectation waiting: status %0d", result.status);
					failures++;
				end else begin
					e = expected_q.pop_front();
					if (result.status !== e.st) begin
						$error("status: expected %0d, actual %0d", e.st, result.status);
						failures++;
					end
					if (result.row_index !== e.row) begin
						$error("row_index: expected %0d, actual %0d", e.row, result.row_index);
						failures++;
					end
					if (result.entry_value !== e.val) begin
						$error("entry_value: expected %0d, actual %0d", e.val,
							result.entry_value);
						failures++;
					end
					if (result.entries_used !== e.used) begin
						$error("entries_used: expected %0d, actual %0d", e.used,
							result.entries_used);
						failures++;
					end
				end
			end
			if (item.valid && item.ready)
				expected_q.push_back(predict_entry(op_t'(item.operation), item.row, item.column,
					item.amount, item.definitely_new, item.capacity, item.slot));
			pending <= expected_q.size();
		end
	end

	final begin
	end

endmodule

// ===== verif/tb.sv =====
// testbench top of the sparse column matrix assembler: clock, reset, stimulus and verdict
// depends on scma_pkg, scma_if, the block and scma_checker

module tb;
	import scma_pkg::*;

	localparam int N_COLS = 20;     // final matrix size used for the run
	localparam int N_RANDOM = 1250;

	logic clk = 0;
	logic arst_n = 0;
	int   pending;
	int   failures;
	bit   hold_req = 0;
	int   cap_of [N_COLS];
	int   n_items = 0;
	int   n_adds = 0;
	int   n_reads = 0;
	int   n_shifts = 0;

	scma_item_if   item_ch();
	scma_result_if res_ch();
	scma_cfg_if    cfg_ch();

	always #5 clk = ~clk;

	sparse_column_matrix_assembler #(.MAX_DIM(256), .MAX_SLOTS(4096)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	scma_checker #(.MAX_DIM(256), .MAX_SLOTS(4096)) CHK (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (res_ch),
		.cfg      (cfg_ch),
		.pending  (pending),
		.failures (failures)
	);

	// sender gap: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// one item transfer; valid stays high across back-to-back items
	task automatic send_item(op_t op, logic [7:0] row, logic [7:0] col, logic [31:0] amt,
			logic nw, logic [12:0] cap, logic [11:0] slot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid = 0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid = 1;
		item_ch.operation = op;
		item_ch.row = row;
		item_ch.column = col;
		item_ch.amount = amt;
		item_ch.definitely_new = nw;
		item_ch.capacity = cap;
		item_ch.slot = slot;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		n_items++;
		if (op == OP_ADD) n_adds++;
		if (op == OP_READ) n_reads++;
		if (op == OP_SHIFT) n_shifts++;
	endtask

	// register write through the config channel
	task automatic write_size(logic [8:0] v);
		cfg_ch.valid = 1;
		cfg_ch.matrix_size = v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 0;
	endtask

	// lets every expected result drain, then a margin for work with no result pending
	task automatic wait_idle();
		item_ch.valid = 0;
		do @(negedge clk); while (pending != 0);
		repeat (100) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_amount();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	// result side: random back-pressure with free-flowing streaks and a long hold on request
	initial begin
		int streak, k;
		streak = 0;
		res_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold so the output register and the item input both stall
				res_ch.ready = 0;
				repeat (500) @(negedge clk);
				hold_req = 0;
			end else if (streak > 0) begin
				res_ch.ready = 1;
				streak--;
			end else begin
				k = $urandom_range(0, 99);
				if (k < 30) streak = $urandom_range(5, 40);
				res_ch.ready = (k % 3 != 0);
				if (k >= 97) begin
					res_ch.ready = 0;
					repeat ($urandom_range(20, 80)) @(negedge clk);
				end
			end
		end
	end

	// run limit: clearing pass plus worst-case searches and stalls, several times over
	initial begin
		#30000000;
		$display("FAIL sparse_column_matrix_assembler");
		$finish;
	end

	initial begin
		int col, row, k, used_cap;
		item_ch.valid = 0;
		item_ch.operation = OP_RESERVE;
		item_ch.row = 0;
		item_ch.column = 0;
		item_ch.amount = 0;
		item_ch.definitely_new = 0;
		item_ch.capacity = 0;
		item_ch.slot = 0;
		cfg_ch.valid = 0;
		cfg_ch.matrix_size = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;

		// size writes before the first reserve all take effect; last one wins
		write_size(9'd256);
		write_size(9'd0);
		write_size(9'd511);
		write_size(9'd1);
		write_size(9'(N_COLS));

		// everything but reserve is refused while reserving; lower add wins over phase
		send_item(OP_ADD, 8'd3, 8'd5, 32'd1, 1'b0, 13'd1, 12'd0);
		send_item(OP_ADD, 8'd9, 8'd2, 32'd1, 1'b0, 13'd1, 12'd0);
		send_item(OP_SHIFT, 8'd0, 8'd0, 32'd7, 1'b0, 13'd1, 12'd0);
		send_item(OP_READ, 8'd0, 8'd0, 32'd0, 1'b0, 13'd1, 12'd0);

		// reserve columns; zero capacity is one slot, oversized ones are refused
		for (col = 0; col < N_COLS; col++) begin
			if (col == 3) send_item(OP_RESERVE, 0, 0, 0, 0, 13'h1fff, 12'hfff);
			if (col == 7) send_item(OP_RESERVE, 0, 0, 0, 0, 13'd4096, 0);
			cap_of[col] = (col == 0) ? 0 : $urandom_range(2, 24);
			send_item(OP_RESERVE, 8'hff, 8'hff, 32'hffffffff, 1'b1, 13'(cap_of[col]), 0);
		end

		wait_idle();
		// late writes are ignored
		write_size(9'd0);
		write_size(9'd511);

		send_item(OP_RESERVE, 0, 0, 0, 0, 13'd5, 0);                  // wrong phase
		send_item(OP_ADD, 8'd255, 8'd255, 32'd1, 0, 0, 0);            // row range
		send_item(OP_ADD, 8'd0, 8'd200, 32'd1, 0, 0, 0);              // column range
		send_item(OP_ADD, 8'd1, 8'd0, 32'd1, 0, 0, 0);                // lower
		send_item(OP_ADD, 8'd0, 8'd0, 32'h7fffffff, 0, 0, 0);         // diagonal
		send_item(OP_ADD, 8'd0, 8'd0, 32'h80000000, 0, 0, 0);
		send_item(OP_ADD, 8'd0, 8'd1, 32'd5, 0, 0, 0);                // column 0 full? no, col 1
		send_item(OP_ADD, 8'd0, 8'd1, 32'd6, 0, 0, 0);                // found in search
		send_item(OP_ADD, 8'd0, 8'd1, 32'd6, 1, 0, 0);                // appended without search
		send_item(OP_READ, 0, 8'd1, 0, 0, 0, 12'd2);
		send_item(OP_READ, 0, 8'd1, 0, 0, 0, 12'hfff);                // bad slot
		send_item(OP_READ, 0, 8'd250, 0, 0, 0, 12'd0);                // column range
		send_item(OP_SHIFT, 0, 0, 32'h00010000, 0, 0, 0);

		// random part: mostly in-range adds with a few rows per column so searches hit
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 100) hold_req = 1;
			if (n == 349) begin
				// saturate one diagonal in both directions
				repeat (300) send_item(OP_ADD, 8'd2, 8'd2, 32'h7fffffff, 0, 0, 0);
				repeat (600) send_item(OP_ADD, 8'd2, 8'd2, 32'h80000000, 0, 0, 0);
				n += 900;
			end
			k = $urandom_range(0, 99);
			col = $urandom_range(0, N_COLS - 1);
			row = $urandom_range(0, col);
			if (k < 55) begin
				send_item(OP_ADD, 8'(row), 8'(col), pick_amount(), ($urandom_range(0, 4) == 0),
					13'($urandom), 12'($urandom));
			end else if (k < 60) begin
				// noise: full-range fields, mostly refused
				send_item(OP_ADD, 8'($urandom), 8'($urandom), $urandom, 1'($urandom),
					13'($urandom), 12'($urandom));
			end else if (k < 88) begin
				used_cap = (cap_of[col] == 0) ? 1 : cap_of[col];
				send_item(OP_READ, 8'($urandom), 8'(col), $urandom, 1'($urandom),
					13'($urandom), ($urandom_range(0, 9) == 0) ? 12'($urandom)
					: 12'($urandom_range(0, used_cap)));
			end else if (k < 93) begin
				send_item(OP_SHIFT, 8'($urandom), 8'($urandom), pick_amount(), 1'($urandom),
					13'($urandom), 12'($urandom));
			end else if (k < 96) begin
				send_item(OP_READ, 8'($urandom), 8'($urandom_range(N_COLS, 255)), $urandom,
					0, 0, 12'($urandom));
			end else begin
				send_item(OP_RESERVE, 8'($urandom), 8'($urandom), $urandom, 1'($urandom),
					13'($urandom), 12'($urandom));
			end
		end

		item_ch.valid = 0;
		do @(negedge clk); while (pending != 0);
		repeat (200) @(negedge clk);

		$display("covered %0d items on a %0d-column matrix: %0d adds, %0d reads, %0d shifts",
			n_items, N_COLS, n_adds, n_reads, n_shifts);
		$display("including refused items, size clamps, late size writes and saturation");
		if (failures == 0) begin
			$display("PASS sparse_column_matrix_assembler");
		end else begin
			$display("FAIL sparse_column_matrix_assembler");
		end
		$finish;
	end

endmodule

// ===== sparse_column_matrix_assembler.f =====
rtl/scma_pkg.sv
rtl/scma_if.sv
rtl/sparse_column_matrix_assembler.sv
verif/scma_checker.sv
verif/tb.sv
